// ----- sv/tea_pkg.sv -----
// tea cipher package: round constants, types and the round mix function
`timescale 1ns / 1ps
`default_nettype none

package tea_pkg;

    localparam int unsigned TEA_ROUNDS     = 32;
    localparam int unsigned TEA_ROUNDS_MAX = 64;
    localparam logic [31:0] TEA_DELTA      = 32'h9E37_79B9;

    // word index of the key registers on the configuration port
    typedef enum logic [1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } tea_reg_t;

    typedef struct packed {
        logic        dec;
        logic [31:0] left;
        logic [31:0] right;
    } tea_beat_t;

    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } tea_key_t;

    // round sum after n additions of delta, modulo 2^32 (elaboration only)
    function automatic logic [31:0] tea_sum(input int unsigned n);
        logic [63:0] prod;
        prod = 64'(TEA_DELTA) * 64'(n);
        return prod[31:0];
    endfunction

    function automatic logic [31:0] tea_mix(
        input logic [31:0] v,
        input logic [31:0] sum,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

endpackage

`default_nettype wire

// ----- sv/tea_round_stage.sv -----
// tea half-round pipeline stage: one word update and its register
`timescale 1ns / 1ps
`default_nettype none

module tea_round_stage
    import tea_pkg::*;
#(
    parameter logic [31:0] SUM_ENC = TEA_DELTA,
    parameter logic [31:0] SUM_DEC = TEA_DELTA,
    parameter bit          SECOND  = 1'b0
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire tea_beat_t in_beat,
    input  wire tea_key_t  keys,
    output logic           out_valid,
    output tea_beat_t      out_beat
);

    logic        valid_reg;
    tea_beat_t   beat_reg;
    tea_beat_t   beat_next;
    logic        src_left;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] sum;
    logic [31:0] mixed;
    logic [31:0] dst_new;

    // encrypt: first half updates left from right, second right from left
    // decrypt: the order is swapped
    always_comb
    begin
        src_left = in_beat.dec ^ SECOND;
        sum      = in_beat.dec ? SUM_DEC : SUM_ENC;
        if (src_left)
        begin
            src = in_beat.left;
            dst = in_beat.right;
            ka  = keys.k2;
            kb  = keys.k3;
        end
        else
        begin
            src = in_beat.right;
            dst = in_beat.left;
            ka  = keys.k0;
            kb  = keys.k1;
        end
        mixed   = tea_mix(src, sum, ka, kb);
        dst_new = in_beat.dec ? (dst - mixed) : (dst + mixed);

        beat_next     = in_beat;
        if (src_left)
        begin
            beat_next.right = dst_new;
        end
        else
        begin
            beat_next.left = dst_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

`default_nettype wire

// ----- sv/tea_block_cipher.sv -----
// tea block cipher top level: key registers, half-round pipeline, output register
// an input beat passes through every half-round stage register, then the output register
// throughput: one block per cycle while the output is not held, set by one half-round adder chain per stage
// the pipeline only halts when its last stage is full and the output beat is held
// reset clears the key words, all stage valid bits and the output valid
`timescale 1ns / 1ps
`default_nettype none

module tea_block_cipher
    import tea_pkg::*;
#(
    parameter int unsigned ROUNDS = TEA_ROUNDS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // block_left [31:0], block_right [63:32]
    input  wire logic [0:0]  s_axis_tuser,  // cmd [0]
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata   // out_left [31:0], out_right [63:32]
);

    localparam int unsigned STAGES = 2 * ROUNDS;

    tea_key_t    key_reg;
    tea_reg_t    wr_sel;
    tea_reg_t    rd_sel;
    logic        apb_wr;

    logic        stage_valid [0:STAGES];
    tea_beat_t   stage_beat  [0:STAGES];
    logic        en;
    logic        out_take;
    logic        out_valid_reg;
    logic [31:0] out_left_reg;
    logic [31:0] out_right_reg;

    // configuration
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;
    assign wr_sel = tea_reg_t'(paddr[3:2]);
    assign rd_sel = tea_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (apb_wr)
        begin
            unique case (wr_sel)
                REG_KEY0: key_reg.k0 <= pwdata;
                REG_KEY1: key_reg.k1 <= pwdata;
                REG_KEY2: key_reg.k2 <= pwdata;
                REG_KEY3: key_reg.k3 <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (rd_sel)
            REG_KEY0: prdata = key_reg.k0;
            REG_KEY1: prdata = key_reg.k1;
            REG_KEY2: prdata = key_reg.k2;
            REG_KEY3: prdata = key_reg.k3;
        endcase
    end

    // pipeline moves unless a finished beat is stuck behind a held output
    assign out_take      = !out_valid_reg || m_axis_tready;
    assign en            = !stage_valid[STAGES] || out_take;
    assign s_axis_tready = en;

    assign stage_valid[0]      = s_axis_tvalid;
    assign stage_beat[0].dec   = s_axis_tuser[0];
    assign stage_beat[0].left  = s_axis_tdata[31:0];
    assign stage_beat[0].right = s_axis_tdata[63:32];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam int unsigned RND = k / 2;

        tea_round_stage #(
            .SUM_ENC (tea_sum(RND + 1)),
            .SUM_DEC (tea_sum(ROUNDS - RND)),
            .SECOND  (k % 2 == 1)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stage_valid[k]),
            .in_beat   (stage_beat[k]),
            .keys      (key_reg),
            .out_valid (stage_valid[k + 1]),
            .out_beat  (stage_beat[k + 1])
        );
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= stage_valid[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && stage_valid[STAGES])
        begin
            out_left_reg  <= stage_beat[STAGES].left;
            out_right_reg <= stage_beat[STAGES].right;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_right_reg, out_left_reg};

`ifndef ASSERT_OFF
    a_halt_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !en |-> (stage_valid[STAGES] && out_valid_reg && !m_axis_tready))
        else $error("pipeline halted while it could move");

    a_last_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && stage_valid[STAGES]) |=> out_valid_reg)
        else $error("finished beat did not reach output register");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> stage_valid[1])
        else $error("accepted beat missing from first stage");

    a_first_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && stage_valid[1]) |=> (stage_valid[1] && $stable(stage_beat[1])))
        else $error("stalled stage changed");
`endif

endmodule

`default_nettype wire
